// ===== src/acc_pkg.sv =====
// acc_pkg: shared types and constants for the aspect-ratio center crop block.
// No dependencies; every module of the block imports it.
package acc_pkg;

    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_TARGET_WIDTH  = 1'b0;
    localparam logic REG_TARGET_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        MODE_FULL,
        MODE_WIDE,
        MODE_TALL
    } acc_mode_t;

    typedef struct packed {
        logic      ok;
        acc_mode_t mode;
    } acc_ctrl_t;

endpackage

// ===== src/acc_size_if.sv =====
// acc_size_if: valid/ready channel carrying one source image size.
// No dependencies.
interface acc_size_if #(parameter int DIM_BITS = 16);
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] source_width;
    logic [DIM_BITS-1:0] source_height;

    modport source (output valid, source_width, source_height, input ready);
    modport sink   (input valid, source_width, source_height, output ready);
endinterface

// ===== src/acc_crop_if.sv =====
// acc_crop_if: valid/ready channel carrying one crop window.
// No dependencies.
interface acc_crop_if #(parameter int DIM_BITS = 16);
    logic                valid;
    logic                ready;
    logic                crop_valid;
    logic [DIM_BITS-1:0] crop_left;
    logic [DIM_BITS-1:0] crop_top;
    logic [DIM_BITS-1:0] crop_width;
    logic [DIM_BITS-1:0] crop_height;

    modport source (output valid, crop_valid, crop_left, crop_top, crop_width, crop_height,
                    input ready);
    modport sink   (input valid, crop_valid, crop_left, crop_top, crop_width, crop_height,
                    output ready);
endinterface

// ===== src/acc_front.sv =====
// acc_front: registers the cross products of source and target sizes, then picks
// the crop direction and the dividend/divisor for the divider chain.
// Depends on acc_pkg.
module acc_front #(
    parameter int DIM_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [DIM_BITS-1:0]   up_sw,
    input  logic [DIM_BITS-1:0]   up_sh,
    input  logic [DIM_BITS-1:0]   target_w,
    input  logic [DIM_BITS-1:0]   target_h,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [DIM_BITS-1:0]   dn_rem,
    output logic [DIM_BITS-1:0]   dn_low,
    output logic [DIM_BITS-1:0]   dn_div,
    output logic [DIM_BITS-1:0]   dn_sw,
    output logic [DIM_BITS-1:0]   dn_sh,
    output acc_pkg::acc_ctrl_t    dn_ctrl
);
    import acc_pkg::*;

    localparam int PROD_W = 2 * DIM_BITS;

    logic                valid_reg, valid_next;
    logic [PROD_W-1:0]   lhs_reg, lhs_next;
    logic [PROD_W-1:0]   rhs_reg, rhs_next;
    logic [DIM_BITS-1:0] sw_reg, sh_reg, tw_reg, th_reg;
    logic                ok_reg, ok_next;
    logic [PROD_W-1:0]   dividend;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        lhs_next   = PROD_W'(up_sw) * PROD_W'(target_h);
        rhs_next   = PROD_W'(up_sh) * PROD_W'(target_w);
        ok_next    = (up_sw != '0) && (up_sh != '0) && (target_w != '0) && (target_h != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
            sw_reg  <= up_sw;
            sh_reg  <= up_sh;
            tw_reg  <= target_w;
            th_reg  <= target_h;
            ok_reg  <= ok_next;
        end
    end

    // source wider: width = rhs / th; source taller: height = lhs / tw
    always_comb
    begin
        dn_ctrl.ok = ok_reg;
        if (lhs_reg > rhs_reg)
        begin
            dn_ctrl.mode = MODE_WIDE;
            dividend     = rhs_reg;
            dn_div       = th_reg;
        end
        else if (lhs_reg < rhs_reg)
        begin
            dn_ctrl.mode = MODE_TALL;
            dividend     = lhs_reg;
            dn_div       = tw_reg;
        end
        else
        begin
            dn_ctrl.mode = MODE_FULL;
            dividend     = '0;
            dn_div       = th_reg;
        end
        if (!ok_reg)
        begin
            dividend = '0;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = dividend[PROD_W-1:DIM_BITS];
    assign dn_low   = dividend[DIM_BITS-1:0];
    assign dn_sw    = sw_reg;
    assign dn_sh    = sh_reg;

endmodule

// ===== src/acc_div_cell.sv =====
// acc_div_cell: one restoring-division step; yields one quotient bit per cell
// and hands the partial remainder to the next cell. Depends on acc_pkg.
module acc_div_cell #(
    parameter int DIM_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [DIM_BITS-1:0]   up_rem,
    input  logic [DIM_BITS-1:0]   up_low,
    input  logic [DIM_BITS-1:0]   up_quo,
    input  logic [DIM_BITS-1:0]   up_div,
    input  logic [DIM_BITS-1:0]   up_sw,
    input  logic [DIM_BITS-1:0]   up_sh,
    input  acc_pkg::acc_ctrl_t    up_ctrl,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [DIM_BITS-1:0]   dn_rem,
    output logic [DIM_BITS-1:0]   dn_low,
    output logic [DIM_BITS-1:0]   dn_quo,
    output logic [DIM_BITS-1:0]   dn_div,
    output logic [DIM_BITS-1:0]   dn_sw,
    output logic [DIM_BITS-1:0]   dn_sh,
    output acc_pkg::acc_ctrl_t    dn_ctrl
);
    import acc_pkg::*;

    logic                valid_reg, valid_next;
    logic [DIM_BITS-1:0] rem_reg, rem_next;
    logic [DIM_BITS-1:0] low_reg, low_next;
    logic [DIM_BITS-1:0] quo_reg, quo_next;
    logic [DIM_BITS-1:0] div_reg, sw_reg, sh_reg;
    acc_ctrl_t           ctrl_reg;
    logic [DIM_BITS:0]   shifted, divx, diff;
    logic                ge;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        shifted    = {up_rem, up_low[DIM_BITS-1]};
        divx       = {1'b0, up_div};
        ge         = shifted >= divx;
        diff       = shifted - divx;
        rem_next   = ge ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
        low_next   = {up_low[DIM_BITS-2:0], 1'b0};
        quo_next   = {up_quo[DIM_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            quo_reg  <= quo_next;
            div_reg  <= up_div;
            sw_reg   <= up_sw;
            sh_reg   <= up_sh;
            ctrl_reg <= up_ctrl;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_low   = low_reg;
    assign dn_quo   = quo_reg;
    assign dn_div   = div_reg;
    assign dn_sw    = sw_reg;
    assign dn_sh    = sh_reg;
    assign dn_ctrl  = ctrl_reg;

endmodule

// ===== src/acc_finish.sv =====
// acc_finish: clamps the quotient, centers the window and holds the result
// in the output register. Depends on acc_pkg.
module acc_finish #(
    parameter int DIM_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [DIM_BITS-1:0]   up_quo,
    input  logic [DIM_BITS-1:0]   up_sw,
    input  logic [DIM_BITS-1:0]   up_sh,
    input  acc_pkg::acc_ctrl_t    up_ctrl,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic                  crop_valid,
    output logic [DIM_BITS-1:0]   crop_left,
    output logic [DIM_BITS-1:0]   crop_top,
    output logic [DIM_BITS-1:0]   crop_width,
    output logic [DIM_BITS-1:0]   crop_height
);
    import acc_pkg::*;

    logic                valid_reg, valid_next;
    logic                cv_reg, cv_next;
    logic [DIM_BITS-1:0] left_reg, left_next;
    logic [DIM_BITS-1:0] top_reg, top_next;
    logic [DIM_BITS-1:0] cw_reg, cw_next;
    logic [DIM_BITS-1:0] ch_reg, ch_next;
    logic [DIM_BITS-1:0] q1, spare;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        q1         = (up_quo == '0) ? DIM_BITS'(1) : up_quo;
        cv_next    = up_ctrl.ok;
        left_next  = '0;
        top_next   = '0;
        cw_next    = up_sw;
        ch_next    = up_sh;
        spare      = '0;
        case (up_ctrl.mode)
            MODE_WIDE:
            begin
                cw_next   = q1;
                spare     = up_sw - q1;
                left_next = spare >> 1;
            end
            MODE_TALL:
            begin
                ch_next  = q1;
                spare    = up_sh - q1;
                top_next = spare >> 1;
            end
            default:
            begin
                spare = '0;
            end
        endcase
        if (!up_ctrl.ok)
        begin
            left_next = '0;
            top_next  = '0;
            cw_next   = '0;
            ch_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            cv_reg   <= cv_next;
            left_reg <= left_next;
            top_reg  <= top_next;
            cw_reg   <= cw_next;
            ch_reg   <= ch_next;
        end
    end

    assign dn_valid    = valid_reg;
    assign crop_valid  = cv_reg;
    assign crop_left   = left_reg;
    assign crop_top    = top_reg;
    assign crop_width  = cw_reg;
    assign crop_height = ch_reg;

endmodule

// ===== src/aspect_center_crop.sv =====
// aspect_center_crop: top level; APB target-size registers, cross-product front,
// row of division cells and output stage. Depends on acc_pkg, acc_size_if,
// acc_crop_if, acc_front, acc_div_cell, acc_finish.
//
// Usage:
//   size : valid/ready sink; one transfer carries source_width/source_height.
//   crop : valid/ready source; one transfer per accepted size carries the
//          largest centered window with the target aspect ratio, or
//          crop_valid = 0 with zero fields when any size is zero.
//   APB  : target_width at 0x0, target_height at 0x4; write only while idle.
// Pipeline: the cross products register at the size transfer edge, then the
//   cell row registers one quotient bit per cell, and the output register
//   holds the finished crop window.
// Throughput: one size per cycle; every stage holds its own valid flag, so
//   the row keeps filling behind a stalled crop channel until it is full,
//   and size.ready falls only then.
// Reset: targets return to 1x1, all stages empty, crop.valid low.
module aspect_center_crop #(
    parameter int DIM_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    acc_size_if.sink                      size,
    acc_crop_if.source                    crop,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acc_pkg::PADDR_W-1:0]   paddr,
    input  logic [acc_pkg::PDATA_W-1:0]   pwdata,
    output logic [acc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import acc_pkg::*;

    logic [DIM_BITS-1:0] tw_reg, tw_next;
    logic [DIM_BITS-1:0] th_reg, th_next;

    assign pready = 1'b1;

    always_comb
    begin
        tw_next = tw_reg;
        th_next = th_reg;
        if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_TARGET_WIDTH:  tw_next = pwdata[DIM_BITS-1:0];
                REG_TARGET_HEIGHT: th_next = pwdata[DIM_BITS-1:0];
                default:           tw_next = tw_reg;
            endcase
        end
        prdata = (paddr[2] == REG_TARGET_HEIGHT) ? PDATA_W'(th_reg) : PDATA_W'(tw_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= DIM_BITS'(1);
            th_reg <= DIM_BITS'(1);
        end
        else
        begin
            tw_reg <= tw_next;
            th_reg <= th_next;
        end
    end

    logic                valid_s [DIM_BITS+1];
    logic                ready_s [DIM_BITS+1];
    logic [DIM_BITS-1:0] rem_s   [DIM_BITS+1];
    logic [DIM_BITS-1:0] low_s   [DIM_BITS+1];
    logic [DIM_BITS-1:0] quo_s   [DIM_BITS+1];
    logic [DIM_BITS-1:0] div_s   [DIM_BITS+1];
    logic [DIM_BITS-1:0] sw_s    [DIM_BITS+1];
    logic [DIM_BITS-1:0] sh_s    [DIM_BITS+1];
    acc_ctrl_t           ctrl_s  [DIM_BITS+1];

    assign quo_s[0] = '0;

    acc_front #(.DIM_BITS(DIM_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (size.valid),
        .up_ready (size.ready),
        .up_sw    (size.source_width),
        .up_sh    (size.source_height),
        .target_w (tw_reg),
        .target_h (th_reg),
        .dn_valid (valid_s[0]),
        .dn_ready (ready_s[0]),
        .dn_rem   (rem_s[0]),
        .dn_low   (low_s[0]),
        .dn_div   (div_s[0]),
        .dn_sw    (sw_s[0]),
        .dn_sh    (sh_s[0]),
        .dn_ctrl  (ctrl_s[0])
    );

    for (genvar i = 0; i < DIM_BITS; i++)
    begin : g_cell
        acc_div_cell #(.DIM_BITS(DIM_BITS)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_s[i]),
            .up_ready (ready_s[i]),
            .up_rem   (rem_s[i]),
            .up_low   (low_s[i]),
            .up_quo   (quo_s[i]),
            .up_div   (div_s[i]),
            .up_sw    (sw_s[i]),
            .up_sh    (sh_s[i]),
            .up_ctrl  (ctrl_s[i]),
            .dn_valid (valid_s[i+1]),
            .dn_ready (ready_s[i+1]),
            .dn_rem   (rem_s[i+1]),
            .dn_low   (low_s[i+1]),
            .dn_quo   (quo_s[i+1]),
            .dn_div   (div_s[i+1]),
            .dn_sw    (sw_s[i+1]),
            .dn_sh    (sh_s[i+1]),
            .dn_ctrl  (ctrl_s[i+1])
        );
    end

    acc_finish #(.DIM_BITS(DIM_BITS)) u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (valid_s[DIM_BITS]),
        .up_ready    (ready_s[DIM_BITS]),
        .up_quo      (quo_s[DIM_BITS]),
        .up_sw       (sw_s[DIM_BITS]),
        .up_sh       (sh_s[DIM_BITS]),
        .up_ctrl     (ctrl_s[DIM_BITS]),
        .dn_valid    (crop.valid),
        .dn_ready    (crop.ready),
        .crop_valid  (crop.crop_valid),
        .crop_left   (crop.crop_left),
        .crop_top    (crop.crop_top),
        .crop_width  (crop.crop_width),
        .crop_height (crop.crop_height)
    );

`ifndef SYNTH
    // invalid result carries an all-zero window
    assert property (@(posedge clk) disable iff (!rst_n)
        crop.valid && !crop.crop_valid |->
            crop.crop_left == '0 && crop.crop_top == '0 &&
            crop.crop_width == '0 && crop.crop_height == '0)
    else $error("invalid crop with nonzero window");

    // a computed window is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        crop.valid && crop.crop_valid |-> crop.crop_width != '0 && crop.crop_height != '0)
    else $error("computed crop window is empty");

    // centering moves the window along one axis only
    assert property (@(posedge clk) disable iff (!rst_n)
        crop.valid |-> crop.crop_left == '0 || crop.crop_top == '0)
    else $error("crop offset on both axes");

    // target registers change only through an APB write
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(psel && penable && pwrite) |-> $stable(tw_reg) && $stable(th_reg))
    else $error("target size changed without a write");
`endif

endmodule

// ===== verif/aspect_center_crop_checker.sv =====
`timescale 1ns / 1ps
// aspect_center_crop_checker: watches the APB, size and crop channels, predicts each
// crop window and compares it against the DUT output.
// Depends on acc_pkg, acc_size_if, acc_crop_if.
module aspect_center_crop_checker #(
    parameter int DIM_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    acc_size_if                           size_ch,
    acc_crop_if                           crop_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acc_pkg::PADDR_W-1:0]   paddr,
    input  logic [acc_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);
    import acc_pkg::*;

    typedef struct packed {
        logic                ok;
        logic [DIM_BITS-1:0] left;
        logic [DIM_BITS-1:0] top;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } crop_win_t;

    logic [DIM_BITS-1:0] target_w;
    logic [DIM_BITS-1:0] target_h;
    crop_win_t           window_q[$];
    crop_win_t           got;
    crop_win_t           want;
    int                  report_count;

    function automatic crop_win_t center_crop(input logic [DIM_BITS-1:0] sw, sh, tw, th);
        logic [2*DIM_BITS-1:0] wide_prod;
        logic [2*DIM_BITS-1:0] tall_prod;
        logic [2*DIM_BITS-1:0] span;
        acc_mode_t             mode;
        crop_win_t             win;
        win = '0;
        if (sw == 0 || sh == 0 || tw == 0 || th == 0)
            return win;
        wide_prod = (2*DIM_BITS)'(sw) * (2*DIM_BITS)'(th);
        tall_prod = (2*DIM_BITS)'(sh) * (2*DIM_BITS)'(tw);
        if (wide_prod > tall_prod)
            mode = MODE_WIDE;
        else if (wide_prod < tall_prod)
            mode = MODE_TALL;
        else
            mode = MODE_FULL;
        win.ok     = 1'b1;
        win.width  = sw;
        win.height = sh;
        case (mode)
            MODE_WIDE:
            begin
                span = tall_prod / (2*DIM_BITS)'(th);
                if (span == 0)
                    span = 1;
                win.width = span[DIM_BITS-1:0];
                win.left  = (sw - win.width) >> 1;
            end
            MODE_TALL:
            begin
                span = wide_prod / (2*DIM_BITS)'(tw);
                if (span == 0)
                    span = 1;
                win.height = span[DIM_BITS-1:0];
                win.top    = (sh - win.height) >> 1;
            end
            default:
            begin
            end
        endcase
        return win;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            target_w     = 1;
            target_h     = 1;
            window_q.delete();
            fail_count   = 0;
            report_count = 0;
        end
        else
        begin
            if (crop_ch.valid && crop_ch.ready)
            begin
                got.ok     = crop_ch.crop_valid;
                got.left   = crop_ch.crop_left;
                got.top    = crop_ch.crop_top;
                got.width  = crop_ch.crop_width;
                got.height = crop_ch.crop_height;
                if (window_q.size() == 0)
                begin
                    fail_count++;
                    if (report_count < 10)
                        $display({"%0t: unexpected crop transfer ",
                                  "ok=%0d left=%0d top=%0d w=%0d h=%0d"},
                                 $realtime, got.ok, got.left, got.top, got.width, got.height);
                    report_count++;
                end
                else
                begin
                    want = window_q.pop_front();
                    if (got.ok !== want.ok || got.left !== want.left || got.top !== want.top ||
                        got.width !== want.width || got.height !== want.height)
                    begin
                        fail_count++;
                        if (report_count < 10)
                            $display({"%0t: crop mismatch: expected ok=%0d left=%0d top=%0d ",
                                      "w=%0d h=%0d, got ok=%0d left=%0d top=%0d w=%0d h=%0d"},
                                     $realtime, want.ok, want.left, want.top, want.width,
                                     want.height, got.ok, got.left, got.top, got.width,
                                     got.height);
                        report_count++;
                    end
                end
            end
            if (size_ch.valid && size_ch.ready)
                window_q.push_back(center_crop(size_ch.source_width, size_ch.source_height,
                                               target_w, target_h));
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_TARGET_WIDTH)
                    target_w = pwdata[DIM_BITS-1:0];
                else
                    target_h = pwdata[DIM_BITS-1:0];
            end
        end
        pending = window_q.size();
    end

endmodule

// ===== verif/aspect_center_crop_tb.sv =====
`timescale 1ns / 1ps
// aspect_center_crop_tb: drives size transfers and target-size writes into the DUT with
// random gaps and crop backpressure; verdict from the checker. Depends on acc_pkg, the channel
// interfaces, aspect_center_crop and aspect_center_crop_checker.
module aspect_center_crop_tb;
    import acc_pkg::*;

    localparam int DIM_BITS        = 16;
    localparam int IDLE_LIMIT      = 5000;
    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 120;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                  fail_count;
    int                  pending;
    int                  ready_mode;
    int                  stall_left;
    bit                  burst;
    logic [DIM_BITS-1:0] cur_tw;
    logic [DIM_BITS-1:0] cur_th;

    acc_size_if #(.DIM_BITS(DIM_BITS)) size_ch ();
    acc_crop_if #(.DIM_BITS(DIM_BITS)) crop_ch ();

    aspect_center_crop #(.DIM_BITS(DIM_BITS)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .size    (size_ch),
        .crop    (crop_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    aspect_center_crop_checker #(.DIM_BITS(DIM_BITS)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .size_ch    (size_ch),
        .crop_ch    (crop_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // crop backpressure: mode 0 never stalls, 1 light, 2 heavy with long stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            crop_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            case (ready_mode)
                0: crop_ch.ready <= 1'b1;
                1: crop_ch.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if ($urandom_range(0, 29) == 0)
                    begin
                        stall_left = $urandom_range(10, 40);
                        crop_ch.ready <= 1'b0;
                    end
                    else
                        crop_ch.ready <= ($urandom_range(0, 1) != 0);
                end
            endcase
        end
    end

    function automatic int next_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DIM_BITS-1:0] rand_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        if (r < 15)
            return 1;
        if (r < 40)
            return DIM_BITS'($urandom_range(1, 64));
        if (r < 70)
            return DIM_BITS'($urandom_range(1, 4096));
        return DIM_BITS'($urandom);
    endfunction

    task automatic send_size(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            size_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        size_ch.valid         <= 1'b1;
        size_ch.source_width  <= w;
        size_ch.source_height <= h;
        do
            @(posedge clk);
        while (!size_ch.ready);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [DIM_BITS-1:0] val);
        logic [PDATA_W-1:0] word;
        word                 = $urandom;
        word[DIM_BITS-1:0]   = val;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        size_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_target(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
        drain();
        apb_write(REG_TARGET_WIDTH, w);
        apb_write(REG_TARGET_HEIGHT, h);
        cur_tw = w;
        cur_th = h;
    endtask

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (size_ch.valid && size_ch.ready) || (crop_ch.valid && crop_ch.ready) ||
                (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("** aspect_center_crop: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int                  r;
        int                  k;
        int                  m;
        logic [DIM_BITS-1:0] tw;
        logic [DIM_BITS-1:0] th;

        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        size_ch.valid         = 1'b0;
        size_ch.source_width  = '0;
        size_ch.source_height = '0;
        crop_ch.ready         = 1'b0;
        ready_mode            = 1;
        stall_left            = 0;
        burst                 = 1'b0;
        cur_tw                = 1;
        cur_th                = 1;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset targets 1x1, zero sizes, extremes, odd leftovers
        send_size(0, 0);
        send_size(0, 5);
        send_size(5, 0);
        send_size(1, 1);
        send_size(16'hFFFF, 16'hFFFF);
        send_size(16'hFFFF, 1);
        send_size(1, 16'hFFFF);
        send_size(1920, 1080);
        send_size(7, 4);
        send_size(4, 7);
        // crop width/height floors to zero and is clamped to one
        set_target(1, 16'hFFFF);
        send_size(16'hFFFF, 1);
        send_size(3, 2);
        set_target(16'hFFFF, 1);
        send_size(1, 16'hFFFF);
        set_target(16, 9);
        send_size(1920, 1080);
        send_size(1080, 1920);
        set_target(0, 16'hFFFF);
        send_size(100, 100);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: begin tw = 1; th = 1; end
                1: begin tw = 16'hFFFF; th = 16'hFFFF; end
                2: begin tw = 0; th = DIM_BITS'($urandom); end
                3: begin tw = DIM_BITS'($urandom); th = 0; end
                4: begin tw = 4; th = 3; end
                5: begin tw = 3; th = 4; end
                6: begin tw = 1; th = 16'hFFFF; end
                7: begin tw = 16'hFFFF; th = 1; end
                8: begin tw = 16; th = 9; end
                default:
                begin
                    if ($urandom_range(0, 1) != 0)
                    begin
                        tw = DIM_BITS'($urandom_range(1, 32));
                        th = DIM_BITS'($urandom_range(1, 32));
                    end
                    else
                    begin
                        tw = DIM_BITS'($urandom);
                        th = DIM_BITS'($urandom);
                    end
                end
            endcase
            set_target(tw, th);
            ready_mode = p % 3;
            burst      = (p % 4 == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 4 && n == ITEMS_PER_PHASE / 2)
                    drain();
                r = $urandom_range(0, 99);
                m = (cur_tw > cur_th) ? int'(cur_tw) : int'(cur_th);
                if (r < 15 && cur_tw != 0 && cur_th != 0 && m <= 256)
                begin
                    // exact target ratio: whole frame
                    k = $urandom_range(1, 65535 / m);
                    send_size(DIM_BITS'(int'(cur_tw) * k), DIM_BITS'(int'(cur_th) * k));
                end
                else
                    send_size(rand_dim(), rand_dim());
            end
        end

        drain();
        repeat (DIM_BITS + 8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** aspect_center_crop: PASSED **");
        else
            $display("** aspect_center_crop: FAILED **");
        $finish;
    end

endmodule
